// ===== rtl/sol_pkg.sv =====
// ----------------------------------------------------------------------------
// sol_pkg
// Shared codes and controller/datapath interface types for the open list.
// ----------------------------------------------------------------------------
package sol_pkg;

	// request commands
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// result status
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef enum logic [1:0] {RA_IDX, RA_DOWN, RA_UP} rd_addr_sel_t;
	typedef enum logic [1:0] {IDX_HOLD, IDX_INC, IDX_DEC, IDX_CNT} idx_op_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_t;

	typedef struct packed {
		logic         take;       // latch request, zero index and hit
		logic         rd_en;
		rd_addr_sel_t rd_sel;
		idx_op_t      idx_op;
		logic         at_load;    // insert point <= index
		logic         wr_en;
		logic         wr_new;     // write request at insert point, else shift data
		cnt_op_t      cnt_op;
		logic         hit_load;
		logic         out_load;
		logic [1:0]   out_status;
	} ctl_t;

	typedef struct packed {
		logic [1:0] op;
		logic       idx_at_cnt;
		logic       f_ge;
		logic       pos_eq;
		logic       idx_gt_at;
		logic       up_ok;
		logic       full;
		logic       out_free;
	} stat_t;

endpackage

// ===== rtl/sorted_open_list_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_open_list_unit
// f-ordered open list for grid path search: insert, delete, search, clear.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_*      in   command, pos_x, pos_y, f_score, g_score, h_score
// m_*      out  status, found_x, found_y, found_f, found_g, found_h, entry_count
//
// One request at a time. Clear and insert-into-full go straight to the response.
// Scans read each entry examined through the memory's registered port; insert and
// delete then move each entry with a read and a write; insert adds the final write.
// A finished result waits in the output register; the next request is taken
// while it waits. Reset empties the list; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_open_list_unit #(
	parameter int CAPACITY   = 64,
	parameter int COORD_BITS = 10,
	parameter int SCORE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// command, pos_x, pos_y, f_score, g_score, h_score
	input  logic [((2 + 2*COORD_BITS + 3*SCORE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// status, found_x, found_y, found_f, found_g, found_h, entry_count
	output logic [((2 + 2*COORD_BITS + 3*SCORE_BITS + $clog2(CAPACITY + 1) + 7) / 8)
		* 8 - 1:0] m_tdata
);

	localparam int IN_W  = ((2 + 2*COORD_BITS + 3*SCORE_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((2 + 2*COORD_BITS + 3*SCORE_BITS + $clog2(CAPACITY + 1) + 7)
		/ 8) * 8;

	sol_pkg::ctl_t  ctl;
	sol_pkg::stat_t st;

	sol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.ctl      (ctl)
	);

	sol_dpath #(
		.CAPACITY   (CAPACITY),
		.COORD_BITS (COORD_BITS),
		.SCORE_BITS (SCORE_BITS),
		.IN_W       (IN_W),
		.OUT_W      (OUT_W)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.st       (st),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== rtl/sol_ctrl.sv =====
// ----------------------------------------------------------------------------
// sol_ctrl
// Sequencer for scan, shift and response of each open list request.
// ----------------------------------------------------------------------------
module sol_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  sol_pkg::stat_t st,
	output sol_pkg::ctl_t  ctl
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SH_RD, S_SH_WR, S_PUT, S_RESP
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] status_q, status_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		ctl            = '0;
		ctl.rd_sel     = sol_pkg::RA_IDX;
		ctl.idx_op     = sol_pkg::IDX_HOLD;
		ctl.cnt_op     = sol_pkg::CNT_HOLD;
		ctl.out_status = status_q;
		state_d        = state_q;
		status_d       = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					ctl.take = 1'b1;
					state_d  = S_SCAN_RD;
					status_d = sol_pkg::ST_DONE;
				end
			end
			S_SCAN_RD: begin
				if (st.op == sol_pkg::CMD_CLEAR) begin
					ctl.cnt_op = sol_pkg::CNT_CLR;
					state_d    = S_RESP;
				end else if (st.op == sol_pkg::CMD_INSERT && st.full) begin
					status_d = sol_pkg::ST_FULL;
					state_d  = S_RESP;
				end else if (st.idx_at_cnt) begin
					if (st.op == sol_pkg::CMD_INSERT) begin
						ctl.at_load = 1'b1;
						state_d     = S_SH_RD;
					end else begin
						status_d = sol_pkg::ST_MISSING;
						state_d  = S_RESP;
					end
				end else begin
					ctl.rd_en = 1'b1;
					state_d   = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (st.op == sol_pkg::CMD_INSERT && st.f_ge) begin
					ctl.at_load = 1'b1;
					ctl.idx_op  = sol_pkg::IDX_CNT;
					state_d     = S_SH_RD;
				end else if (st.op == sol_pkg::CMD_DELETE && st.pos_eq) begin
					state_d = S_SH_RD;
				end else if (st.op == sol_pkg::CMD_SEARCH && st.pos_eq) begin
					ctl.hit_load = 1'b1;
					state_d      = S_RESP;
				end else begin
					ctl.idx_op = sol_pkg::IDX_INC;
					state_d    = S_SCAN_RD;
				end
			end
			S_SH_RD: begin
				if (st.op == sol_pkg::CMD_INSERT) begin
					if (st.idx_gt_at) begin
						ctl.rd_en  = 1'b1;
						ctl.rd_sel = sol_pkg::RA_DOWN;
						state_d    = S_SH_WR;
					end else begin
						state_d = S_PUT;
					end
				end else if (st.up_ok) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = sol_pkg::RA_UP;
					state_d    = S_SH_WR;
				end else begin
					ctl.cnt_op = sol_pkg::CNT_DEC;
					state_d    = S_RESP;
				end
			end
			S_SH_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.idx_op = (st.op == sol_pkg::CMD_INSERT) ? sol_pkg::IDX_DEC
				                                            : sol_pkg::IDX_INC;
				state_d    = S_SH_RD;
			end
			S_PUT: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_new = 1'b1;
				ctl.cnt_op = sol_pkg::CNT_INC;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (st.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= sol_pkg::ST_DONE;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

// ===== rtl/sol_dpath.sv =====
// ----------------------------------------------------------------------------
// sol_dpath
// Entry memory, count, scan index, request and result registers.
// ----------------------------------------------------------------------------
module sol_dpath #(
	parameter int CAPACITY   = 64,
	parameter int COORD_BITS = 10,
	parameter int SCORE_BITS = 16,
	parameter int IN_W       = 72,
	parameter int OUT_W      = 80
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sol_pkg::ctl_t                    ctl,
	output sol_pkg::stat_t                   st,
	input  logic [IN_W-1:0]                  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_W-1:0]                 m_tdata
);

	localparam int AW  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int PW  = 2 * COORD_BITS;
	localparam int EW  = PW + 3 * SCORE_BITS;
	localparam int RES = 2 + EW + CW;

	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rdata_q;
	logic [EW-1:0] req_q;
	logic [1:0]    op_q;
	logic [CW-1:0] cnt_q, idx_q, at_q;
	logic [EW-1:0] hit_q;
	logic          m_tvalid_q;
	logic [RES-1:0] res_q;
	logic [CW-1:0] rd_idx, wr_idx;
	logic [CW-1:0] idx_up;

	assign idx_up = idx_q + CW'(1);

	always_comb begin
		case (ctl.rd_sel)
			sol_pkg::RA_DOWN: rd_idx = idx_q - CW'(1);
			sol_pkg::RA_UP:   rd_idx = idx_up;
			default:          rd_idx = idx_q;
		endcase
	end

	assign wr_idx = ctl.wr_new ? at_q : idx_q;

	always_ff @(posedge clk) begin
		if (ctl.rd_en)
			rdata_q <= mem[rd_idx[AW-1:0]];
		if (ctl.wr_en)
			mem[wr_idx[AW-1:0]] <= ctl.wr_new ? req_q : rdata_q;
	end

	// request and entry payload: {h, g, f, y, x} with x lowest
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			op_q  <= s_tdata[1:0];
			req_q <= s_tdata[2 +: EW];
		end
		if (ctl.at_load)
			at_q <= idx_q;
		if (ctl.out_load)
			res_q <= {cnt_q, hit_q, ctl.out_status};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			hit_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.take)
				hit_q <= '0;
			else if (ctl.hit_load)
				hit_q <= rdata_q;
			if (ctl.take)
				idx_q <= '0;
			else begin
				case (ctl.idx_op)
					sol_pkg::IDX_INC: idx_q <= idx_up;
					sol_pkg::IDX_DEC: idx_q <= idx_q - CW'(1);
					sol_pkg::IDX_CNT: idx_q <= cnt_q;
					default:          idx_q <= idx_q;
				endcase
			end
			case (ctl.cnt_op)
				sol_pkg::CNT_INC: cnt_q <= cnt_q + CW'(1);
				sol_pkg::CNT_DEC: cnt_q <= cnt_q - CW'(1);
				sol_pkg::CNT_CLR: cnt_q <= '0;
				default:          cnt_q <= cnt_q;
			endcase
			if (ctl.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign st.op         = op_q;
	assign st.idx_at_cnt = (idx_q == cnt_q);
	assign st.f_ge       = (rdata_q[PW +: SCORE_BITS] >= req_q[PW +: SCORE_BITS]);
	assign st.pos_eq     = (rdata_q[PW-1:0] == req_q[PW-1:0]);
	assign st.idx_gt_at  = (idx_q > at_q);
	assign st.up_ok      = (idx_up < cnt_q);
	assign st.full       = (cnt_q >= CW'(CAPACITY));
	assign st.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(res_q);

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en && ctl.wr_new |-> cnt_q < CW'(CAPACITY))
		else $error("insert write into a full list");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tready |-> !ctl.out_load)
		else $error("result overwritten before it was taken");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load && ctl.out_status != sol_pkg::ST_DONE |-> hit_q == '0)
		else $error("hit data on a failed request");
`endif

endmodule
